### sv/sliding_window_peak_event_count_defines.svh
`ifndef SLIDING_WINDOW_PEAK_EVENT_COUNT_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_EVENT_COUNT_DEFINES_SVH

// Implication checked in the same cycle, clocked on clk, off during rst
`define SWPEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle
`define SWPEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/swpec_pkg.sv
`default_nettype none

package swpec_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [31:0] WINDOW_RESET = 32'd60;
  localparam logic [3:0]  MONTHS_YEAR  = 4'd12;
  // shift that keeps the year count positive (one 400-year era)
  localparam logic [12:0] ERA_YEARS    = 13'd400;
  // days from the shifted calendar origin to 1970-01-01, plus one for day 1
  localparam logic [22:0] DAY_BIAS     = 23'd865566;

  typedef struct packed {
    logic load_in;
    logic conv_a;
    logic conv_b;
    logic conv_c;
    logic conv_d;
    logic conv_e;
    logic pop;
    logic push;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fifo_empty;
    logic pop_ok;
    logic out_free;
  } sts_t;

  // day of a March-based year on which the month starts; m0 = 0 is January
  function automatic logic [8:0] doy_lut(input logic [3:0] m0);
    logic [8:0] d;
    unique case (m0)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      4'd11:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // floor(x / 100) for x below 8192 by reciprocal multiply
  function automatic logic [6:0] div100(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd5243;
    return p[25:19];
  endfunction

endpackage

`default_nettype wire

### sv/swpec_ctrl.sv
`default_nettype none

module swpec_ctrl
  import swpec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CA, S_CB, S_CC, S_CD, S_CE,
    S_POP_RD, S_POP_CHK, S_PUSH, S_RD_OLD, S_UPDATE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CA;
        end
      end
      S_CA: begin
        cmd.conv_a = 1'b1;
        state_next = S_CB;
      end
      S_CB: begin
        cmd.conv_b = 1'b1;
        state_next = S_CC;
      end
      S_CC: begin
        cmd.conv_c = 1'b1;
        state_next = S_CD;
      end
      S_CD: begin
        cmd.conv_d = 1'b1;
        state_next = S_CE;
      end
      S_CE: begin
        cmd.conv_e = 1'b1;
        state_next = S_POP_RD;
      end
      // head data settles here after a pop
      S_POP_RD: begin
        state_next = sts.fifo_empty ? S_PUSH : S_POP_CHK;
      end
      S_POP_CHK: begin
        if (sts.pop_ok) begin
          cmd.pop    = 1'b1;
          state_next = S_POP_RD;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_RD_OLD;
      end
      S_RD_OLD: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

`default_nettype wire

### sv/swpec_dp.sv
`default_nettype none

module swpec_dp
  import swpec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic [4:0]        day_of_month,
  input  logic [3:0]        month_index,
  input  logic [11:0]       year,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [5:0]        seconds_field,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  window_count,
  output logic [CNT_W-1:0]  peak_count,
  output logic [31:0]       peak_start_time,
  output logic [31:0]       peak_end_time,
  output logic              overflow
);

  logic [31:0] window_seconds;

  // latched request fields
  logic [4:0]  day_r;
  logic [3:0]  mon_r;
  logic [11:0] year_r;
  logic [4:0]  hr_r;
  logic [5:0]  mi_r;
  logic [5:0]  se_r;

  // date conversion stages
  logic [12:0] yy;
  logic [8:0]  doy;
  logic [20:0] y365;
  logic [10:0] q4;
  logic [6:0]  q100;
  logic [6:0]  q400;
  logic [9:0]  dsum;
  logic [22:0] days;
  logic [16:0] hms;
  logic signed [40:0] secs;
  logic [31:0] t;

  logic        carry;
  logic [3:0]  m0;
  logic [12:0] yy_next;
  logic signed [40:0] secs_next;

  // timestamp queue
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_data;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [ADDR_W-1:0] head_inc;
  logic [ADDR_W-1:0] tail_inc;
  logic [CNT_W-1:0]  count;
  logic              full;
  logic              ovf;
  logic [32:0]       diff;

  logic [CNT_W-1:0]  peak_value;
  logic [31:0]       peak_start_reg;
  logic [31:0]       peak_end_reg;
  logic              peak_take;

  assign carry   = (mon_r >= MONTHS_YEAR);
  assign m0      = carry ? (mon_r - MONTHS_YEAR) : mon_r;
  // January and February count with the previous year
  assign yy_next = 13'(year_r) + 13'(carry) + ERA_YEARS - 13'(m0 < 4'd2);

  assign secs_next = 41'($signed(days)) * 41'sd86400 + $signed({24'd0, hms});

  assign head_inc = (head == ADDR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == ADDR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign full     = (count == CNT_W'(DEPTH));
  assign diff     = {1'b0, t} - {1'b0, rd_data};
  assign peak_take = (count >= peak_value);

  assign sts.fifo_empty = (count == '0);
  assign sts.pop_ok     = !diff[32] && (diff[31:0] >= window_seconds);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      day_r  <= day_of_month;
      mon_r  <= month_index;
      year_r <= year;
      hr_r   <= hour;
      mi_r   <= minute;
      se_r   <= seconds_field;
    end
    if (cmd.conv_a) begin
      yy  <= yy_next;
      doy <= doy_lut(m0);
    end
    if (cmd.conv_b) begin
      y365 <= 21'(yy) * 21'd365;
      q4   <= yy[12:2];
      q100 <= div100(yy);
      q400 <= div100({2'b0, yy[12:2]});
      dsum <= 10'(doy) + 10'(day_r);
    end
    if (cmd.conv_c) begin
      days <= 23'(y365) + 23'(q4) - 23'(q100) + 23'(q400) + 23'(dsum) - DAY_BIAS;
      hms  <= 17'(hr_r) * 17'd3600 + 17'(mi_r) * 17'd60 + 17'(se_r);
    end
    if (cmd.conv_d) begin
      secs <= secs_next;
    end
    if (cmd.conv_e) begin
      if (secs[40]) begin
        t <= '0;
      end else if (secs[39:32] != '0) begin
        t <= '1;
      end else begin
        t <= secs[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= t;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= WINDOW_RESET;
      head           <= '0;
      tail           <= '0;
      count          <= '0;
      peak_value     <= '0;
      peak_start_reg <= '0;
      peak_end_reg   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_seconds <= cfg_data;
      end
      if (cmd.pop || (cmd.push && full)) begin
        head <= head_inc;
      end
      if (cmd.pop) begin
        count <= count - 1'b1;
      end else if (cmd.push && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.push) begin
        tail <= tail_inc;
      end
      if (cmd.finish && peak_take) begin
        peak_value     <= count;
        peak_start_reg <= rd_data;
        peak_end_reg   <= t;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ovf <= full;
    end
    if (cmd.finish) begin
      window_count    <= count;
      overflow        <= ovf;
      peak_count      <= peak_take ? count : peak_value;
      peak_start_time <= peak_take ? rd_data : peak_start_reg;
      peak_end_time   <= peak_take ? t : peak_end_reg;
    end
  end

endmodule

`default_nettype wire

### sv/sliding_window_peak_event_count.sv
// Sliding-window peak event counter.
// Input channel (in_valid/in_ready): one request timestamp per transfer as
// calendar fields. It is turned into seconds since 1970 (UTC) and queued; queued
// times at least window_seconds older than it are retired first.
// Output channel (out_valid/out_ready): one result per request: entries in the
// window, peak count so far with its start and end times, and an overflow flag
// when a full queue forced out an in-window entry.
// Config channel (cfg_valid/cfg_ready/cfg_data): window length, always ready;
// write it only while no request is in flight.
// Sequence: conversion (states S_CA to S_CE), then retirement of expired
// entries (one head read and compare per entry on the single queue read
// port, with no compare once the queue is empty), then push, oldest-entry
// read and result load. in_ready returns together with out_valid, so a new
// request is taken only once the previous one is through.
// A stalled receiver holds the result register; the next request is still
// taken and converted, and waits in its last stage until the register frees.
// Reset (synchronous rst) empties the queue, clears the peak and sets the
// window to 60 seconds.
`default_nettype none

module sliding_window_peak_event_count
  import swpec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        day_of_month,
  input  logic [3:0]        month_index,
  input  logic [11:0]       year,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [5:0]        seconds_field,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  window_count,
  output logic [CNT_W-1:0]  peak_count,
  output logic [31:0]       peak_start_time,
  output logic [31:0]       peak_end_time,
  output logic              overflow,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  swpec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swpec_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .day_of_month    (day_of_month),
    .month_index     (month_index),
    .year            (year),
    .hour            (hour),
    .minute          (minute),
    .seconds_field   (seconds_field),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .window_count    (window_count),
    .peak_count      (peak_count),
    .peak_start_time (peak_start_time),
    .peak_end_time   (peak_end_time),
    .overflow        (overflow)
  );

endmodule

`default_nettype wire

### sv/swpec_checker.sv
`default_nettype none

`include "sliding_window_peak_event_count_defines.svh"

module swpec_checker
  import swpec_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CNT_W-1:0] window_count,
  input wire logic [CNT_W-1:0] peak_count,
  input wire logic [31:0]      peak_start_time,
  input wire logic [31:0]      peak_end_time,
  input wire logic             overflow
);

  // peak always covers the current window
  `SWPEC_ASSERT_NOW(a_peak_ge_count, out_valid, (window_count != '0) && (peak_count >= window_count), "peak below window count")

  // a dropped entry only happens with the queue full
  `SWPEC_ASSERT_NOW(a_ovf_full, out_valid && overflow, window_count == CNT_W'(DEPTH), "overflow without full queue")

  // one request at a time
  `SWPEC_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

  // held result does not change under stall
  `SWPEC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(peak_count) && $stable(peak_start_time) && $stable(peak_end_time) && $stable(window_count), "result changed under stall")

endmodule

bind sliding_window_peak_event_count swpec_checker u_swpec_checker (.*);

`default_nettype wire
